/* design/brs_pkg.sv */
// Package for the beep repeat sequencer: beat types, opcodes, register
// indexes, reset values of the configuration registers and the sequencer state.
// No dependencies.

package brs_pkg;

	// Command opcodes. Code 3 is unused and changes nothing.
	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_BEEP = 2'd1,
		OP_STOP = 2'd2
	} opcode_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_DURATION = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_DURATION = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_FREQ = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_FREQ     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_FREQ     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_REPEAT   = 3'd5;

	// Register values after reset.
	localparam logic [15:0] RST_MIN_DURATION = 16'd10;
	localparam logic [15:0] RST_MAX_DURATION = 16'd5000;
	localparam logic [15:0] RST_DEFAULT_FREQ = 16'd2000;
	localparam logic [15:0] RST_MIN_FREQ     = 16'd100;
	localparam logic [15:0] RST_MAX_FREQ     = 16'd10000;
	localparam logic [7:0]  RST_MAX_REPEAT   = 8'd10;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] duration_ms;
		logic [15:0] freq_hz;
		logic [7:0]  beep_count;
	} cmd_beat_t;

	typedef struct packed {
		logic        tone_on;
		logic [15:0] tone_freq;
		logic        busy_res;
		logic        accepted;
	} res_beat_t;

	typedef struct packed {
		logic [15:0] min_duration_ms;
		logic [15:0] max_duration_ms;
		logic [15:0] default_freq_hz;
		logic [15:0] min_freq_hz;
		logic [15:0] max_freq_hz;
		logic [7:0]  max_repeat_count;
	} cfg_t;

	typedef struct packed {
		logic        busy_flag;
		logic        in_gap;
		logic [15:0] remaining_ms;
		logic [7:0]  repeats_left;
		logic [15:0] seq_duration;
		logic [15:0] seq_freq;
	} seq_state_t;

endpackage

/* design/brs_step.sv */
// Next-state and result logic of the beep repeat sequencer for one command.
// Depends on brs_pkg.

module brs_step (
	input  brs_pkg::cmd_beat_t  cmd,
	input  brs_pkg::seq_state_t cur,
	input  brs_pkg::cfg_t       cfg,
	output brs_pkg::seq_state_t nxt,
	output brs_pkg::res_beat_t  res
);

	always_comb begin
		logic [15:0] dur;
		logic [15:0] freq;
		logic [7:0]  count;
		logic        acc;

		nxt   = cur;
		acc   = 1'b0;
		dur   = cmd.duration_ms;
		freq  = cmd.freq_hz;
		count = cmd.beep_count;

		// Min is tested first; inverted limits give min below it, max otherwise.
		if (dur < cfg.min_duration_ms) begin
			dur = cfg.min_duration_ms;
		end else if (dur > cfg.max_duration_ms) begin
			dur = cfg.max_duration_ms;
		end
		if (dur == 16'd0) begin
			dur = 16'd1;
		end

		if (freq == 16'd0) begin
			freq = cfg.default_freq_hz;
		end else if (freq < cfg.min_freq_hz) begin
			freq = cfg.min_freq_hz;
		end else if (freq > cfg.max_freq_hz) begin
			freq = cfg.max_freq_hz;
		end

		if (count > cfg.max_repeat_count) begin
			count = cfg.max_repeat_count;
		end
		if (count == 8'd0) begin
			count = 8'd1;
		end

		case (cmd.opcode)
			brs_pkg::OP_TICK: begin
				if (cur.busy_flag) begin
					if (cur.remaining_ms > 16'd1) begin
						nxt.remaining_ms = cur.remaining_ms - 16'd1;
					end else if (cur.in_gap) begin
						nxt.in_gap       = 1'b0;
						nxt.remaining_ms = cur.seq_duration;
					end else if (cur.repeats_left != 8'd0) begin
						nxt.repeats_left = cur.repeats_left - 8'd1;
						nxt.in_gap       = 1'b1;
						nxt.remaining_ms = cur.seq_duration;
					end else begin
						nxt.busy_flag    = 1'b0;
						nxt.remaining_ms = 16'd0;
					end
				end
			end
			brs_pkg::OP_BEEP: begin
				// A zero duration is refused and leaves any running sequence alone.
				if (cmd.duration_ms != 16'd0) begin
					acc              = 1'b1;
					nxt.seq_duration = dur;
					nxt.seq_freq     = freq;
					nxt.repeats_left = count - 8'd1;
					nxt.in_gap       = 1'b0;
					nxt.remaining_ms = dur;
					nxt.busy_flag    = 1'b1;
				end
			end
			brs_pkg::OP_STOP: begin
				if (cur.busy_flag) begin
					nxt.busy_flag    = 1'b0;
					nxt.in_gap       = 1'b0;
					nxt.remaining_ms = 16'd0;
					nxt.repeats_left = 8'd0;
				end
			end
			default: begin
			end
		endcase

		res.tone_on   = nxt.busy_flag & ~nxt.in_gap;
		res.tone_freq = nxt.seq_freq;
		res.busy_res  = nxt.busy_flag;
		res.accepted  = acc;
	end

endmodule

/* design/brs_out_skid.sv */
// Two-entry result buffer of the beep repeat sequencer: an output register
// backed by a skid register, so the core keeps going while a result waits.
// Depends on brs_pkg.

module brs_out_skid (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  brs_pkg::res_beat_t push_data,
	output logic               full,
	output logic               res_valid,
	input  logic               res_stall,
	output brs_pkg::res_beat_t res
);

	brs_pkg::res_beat_t main_q;
	brs_pkg::res_beat_t skid_q;
	logic               main_valid_q;
	logic               skid_valid_q;
	logic               pop;

	assign pop       = main_valid_q & ~res_stall;
	assign full      = skid_valid_q;
	assign res_valid = main_valid_q;
	assign res       = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					main_valid_q <= 1'b1;
					skid_valid_q <= push;
				end else begin
					main_valid_q <= push;
				end
			end else if (!main_valid_q) begin
				main_valid_q <= push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (!main_valid_q) begin
			if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

/* design/beep_repeat_sequencer_unit.sv */
// Top level of the beep repeat sequencer: command register, sequencer state,
// configuration registers and result buffer.
// Depends on brs_pkg, brs_step and brs_out_skid.
//
//   channel   direction  handshake             beat
//   cmd       in         cmd_valid/cmd_stall   brs_pkg::cmd_beat_t
//   res       out        res_valid/res_stall   brs_pkg::res_beat_t
//   cfg       in         cfg_we (no wait)      cfg_index, cfg_data
//
// One command beat is taken every cycle unless cmd_stall is high, and each gives exactly one result beat.
// A beat accepted into the input register is processed once the result buffer
// has room: the state updates and the result enters the buffer, which offers
// it on the res port from its output register.
// The state loop closes through the combinational brs_step.
// The reset clears the state and loads the register defaults.
// A result stall is absorbed by a two-entry buffer; cmd_stall rises only when
// both entries hold and a command waits in the input register.

module beep_repeat_sequencer_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	output logic                                 cmd_stall,
	input  brs_pkg::cmd_beat_t                   cmd,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output brs_pkg::res_beat_t                   res,
	input  logic                                 cfg_we,
	input  logic [brs_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [brs_pkg::CFG_DATA_W-1:0]       cfg_data
);

	brs_pkg::cmd_beat_t  cmd_s1;
	logic                cmd_valid_s1;
	brs_pkg::seq_state_t state_q;
	brs_pkg::seq_state_t state_nxt;
	brs_pkg::cfg_t       cfg_q;
	brs_pkg::res_beat_t  step_res;
	logic                buf_full;
	logic                advance;
	logic                take;

	// The held command moves on whenever the result buffer has room.
	assign advance   = cmd_valid_s1 & ~buf_full;
	assign cmd_stall = cmd_valid_s1 & buf_full;
	assign take      = cmd_valid & ~cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (take) begin
			cmd_valid_s1 <= 1'b1;
		end else if (advance) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd;
		end
	end

	// Sequencer state changes only when a command is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Configuration registers. Writes to indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_duration_ms  <= brs_pkg::RST_MIN_DURATION;
			cfg_q.max_duration_ms  <= brs_pkg::RST_MAX_DURATION;
			cfg_q.default_freq_hz  <= brs_pkg::RST_DEFAULT_FREQ;
			cfg_q.min_freq_hz      <= brs_pkg::RST_MIN_FREQ;
			cfg_q.max_freq_hz      <= brs_pkg::RST_MAX_FREQ;
			cfg_q.max_repeat_count <= brs_pkg::RST_MAX_REPEAT;
		end else if (cfg_we) begin
			case (cfg_index)
				brs_pkg::REG_MIN_DURATION: cfg_q.min_duration_ms  <= cfg_data;
				brs_pkg::REG_MAX_DURATION: cfg_q.max_duration_ms  <= cfg_data;
				brs_pkg::REG_DEFAULT_FREQ: cfg_q.default_freq_hz  <= cfg_data;
				brs_pkg::REG_MIN_FREQ:     cfg_q.min_freq_hz      <= cfg_data;
				brs_pkg::REG_MAX_FREQ:     cfg_q.max_freq_hz      <= cfg_data;
				brs_pkg::REG_MAX_REPEAT:   cfg_q.max_repeat_count <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	brs_step u_step (
		.cmd (cmd_s1),
		.cur (state_q),
		.cfg (cfg_q),
		.nxt (state_nxt),
		.res (step_res)
	);

	brs_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_data (step_res),
		.full      (buf_full),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

/* design/brs_checker.sv */
// Port-level checks for the beep repeat sequencer, bound to the top level.
// Depends on brs_pkg and beep_repeat_sequencer_unit.

module brs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_stall,
	input brs_pkg::cmd_beat_t cmd,
	input logic               res_valid,
	input logic               res_stall,
	input brs_pkg::res_beat_t res
);

	// A stalled command beat stays offered with the same payload.
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
		else $error("command beat changed while stalled");

	// A stalled result beat stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res))
		else $error("result payload changed while stalled");

	// The tone never sounds outside a running sequence.
	a_tone_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.tone_on |-> res.busy_res)
		else $error("tone on while not busy");

	// An accepted beep starts a sequence in its tone phase.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.accepted |-> res.busy_res && res.tone_on)
		else $error("accepted beep did not start a tone");

endmodule

bind beep_repeat_sequencer_unit brs_checker u_brs_checker (.*);

/* tb/beep_sequence_checker.sv */
// Checker for the beep repeat sequencer: tracks the register writes, predicts
// one result beat per accepted command beat and compares results in order.
// Depends on brs_pkg.

module beep_sequence_checker
	import brs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	input  logic                   cmd_stall,
	input  cmd_beat_t              cmd,
	input  logic                   res_valid,
	input  logic                   res_stall,
	input  res_beat_t              res,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     mismatches,
	output int                     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t       limits;
	seq_state_t seq;
	res_beat_t  expected_results[$];

	// Advances the sequencer copy by one command and returns the result it shows.
	function automatic res_beat_t apply_command(input cmd_beat_t c);
		logic [15:0] dur;
		logic [15:0] freq;
		logic [7:0]  count;
		logic        took;
		res_beat_t   r;
		took = 1'b0;
		case (opcode_t'(c.opcode))
			OP_TICK: begin
				if (seq.busy_flag) begin
					if (seq.remaining_ms > 16'd1) begin
						seq.remaining_ms = seq.remaining_ms - 16'd1;
					end else if (seq.in_gap) begin
						seq.in_gap       = 1'b0;
						seq.remaining_ms = seq.seq_duration;
					end else if (seq.repeats_left != 8'd0) begin
						seq.repeats_left = seq.repeats_left - 8'd1;
						seq.in_gap       = 1'b1;
						seq.remaining_ms = seq.seq_duration;
					end else begin
						seq.busy_flag    = 1'b0;
						seq.remaining_ms = '0;
					end
				end
			end
			OP_BEEP: begin
				if (c.duration_ms != 16'd0) begin
					dur = c.duration_ms;
					if (dur < limits.min_duration_ms) begin
						dur = limits.min_duration_ms;
					end else if (dur > limits.max_duration_ms) begin
						dur = limits.max_duration_ms;
					end
					if (dur == 16'd0) begin
						dur = 16'd1;
					end
					freq = c.freq_hz;
					if (freq == 16'd0) begin
						freq = limits.default_freq_hz;
					end else if (freq < limits.min_freq_hz) begin
						freq = limits.min_freq_hz;
					end else if (freq > limits.max_freq_hz) begin
						freq = limits.max_freq_hz;
					end
					count = c.beep_count;
					if (count > limits.max_repeat_count) begin
						count = limits.max_repeat_count;
					end
					if (count == 8'd0) begin
						count = 8'd1;
					end
					seq.seq_duration = dur;
					seq.seq_freq     = freq;
					seq.repeats_left = count - 8'd1;
					seq.in_gap       = 1'b0;
					seq.remaining_ms = dur;
					seq.busy_flag    = 1'b1;
					took             = 1'b1;
				end
			end
			OP_STOP: begin
				if (seq.busy_flag) begin
					seq.busy_flag    = 1'b0;
					seq.in_gap       = 1'b0;
					seq.remaining_ms = '0;
					seq.repeats_left = '0;
				end
			end
			default: begin
			end
		endcase
		r.tone_on   = seq.busy_flag && !seq.in_gap;
		r.tone_freq = seq.seq_freq;
		r.busy_res  = seq.busy_flag;
		r.accepted  = took;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_beat_t want;
		if (!arst_n) begin
			limits = '{RST_MIN_DURATION, RST_MAX_DURATION, RST_DEFAULT_FREQ,
				RST_MIN_FREQ, RST_MAX_FREQ, RST_MAX_REPEAT};
			seq = '0;
			expected_results.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_DURATION: limits.min_duration_ms  = cfg_data;
					REG_MAX_DURATION: limits.max_duration_ms  = cfg_data;
					REG_DEFAULT_FREQ: limits.default_freq_hz  = cfg_data;
					REG_MIN_FREQ:     limits.min_freq_hz      = cfg_data;
					REG_MAX_FREQ:     limits.max_freq_hz      = cfg_data;
					REG_MAX_REPEAT:   limits.max_repeat_count = cfg_data[7:0];
					default: begin
					end
				endcase
			end
			// Results are checked before new commands are queued, so a result can
			// never match a command taken at the same edge.
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display({"%0t: result beat with no command pending: ",
							"tone_on=%0d freq=%0d busy=%0d accepted=%0d"},
							$realtime, res.tone_on, res.tone_freq, res.busy_res,
							res.accepted);
					end
				end else begin
					want = expected_results.pop_front();
					if (res.tone_on !== want.tone_on || res.tone_freq !== want.tone_freq ||
						res.busy_res !== want.busy_res || res.accepted !== want.accepted) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display({"%0t: expected tone_on=%0d freq=%0d busy=%0d ",
								"accepted=%0d, got tone_on=%0d freq=%0d busy=%0d ",
								"accepted=%0d"},
								$realtime, want.tone_on, want.tone_freq, want.busy_res,
								want.accepted, res.tone_on, res.tone_freq, res.busy_res,
								res.accepted);
						end
					end
				end
			end
			if (cmd_valid && !cmd_stall) begin
				expected_results.push_back(apply_command(cmd));
			end
			outstanding = expected_results.size();
		end
	end

endmodule

/* tb/beep_repeat_sequencer_unit_tb.sv */
// Testbench top for the beep repeat sequencer: clock, reset, command and result
// traffic with random idling, register phases and the final verdict.
// Depends on brs_pkg, beep_repeat_sequencer_unit and beep_sequence_checker.

module beep_repeat_sequencer_unit_tb
	import brs_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	// Opcode 3 has no name in the package; it must leave the sequencer untouched.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// The slowest legal run is well under this limit, which leaves a wide margin.
	localparam int unsigned CYCLE_LIMIT     = 300000;
	// Long enough to fill the input register and the two-entry result buffer.
	localparam int unsigned HOLD_OFF_CYCLES = 60;
	// Settling wait after the results have drained, before the next register write.
	localparam int unsigned SETTLE_CYCLES   = 8;

	logic                   clk;
	logic                   arst_n;
	logic                   cmd_valid;
	logic                   cmd_stall;
	cmd_beat_t              cmd;
	logic                   res_valid;
	logic                   res_stall;
	res_beat_t              res;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int          mismatches;
	int          outstanding;
	int unsigned tx_gap_pct;
	int unsigned rx_stall_pct;
	bit          hold_req;

	beep_repeat_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	beep_sequence_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs or never drains.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side. It stalls in random bursts at the rate set for the current
	// phase, and on request holds off for a long stretch so that the block backs
	// up into its command input.
	initial begin : receiver
		int unsigned n;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_stall <= 1'b1;
				n = 0;
				while (n < HOLD_OFF_CYCLES) begin
					@(negedge clk);
					n++;
				end
				res_stall <= 1'b0;
			end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	function automatic cmd_beat_t pack_cmd(input logic [1:0] op, input logic [15:0] dur,
		input logic [15:0] freq, input logic [7:0] count);
		cmd_beat_t c;
		c.opcode      = op;
		c.duration_ms = dur;
		c.freq_hz     = freq;
		c.beep_count  = count;
		return c;
	endfunction

	// Mostly ticks, so that sequences actually run out. Durations are mostly
	// short; zero, the full range and the top value show up too, and so do the
	// zero frequency and count that select the default and a single beep.
	function automatic cmd_beat_t random_cmd();
		cmd_beat_t   c;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			c.opcode = OP_TICK;
		end else if (pick < 82) begin
			c.opcode = OP_BEEP;
		end else if (pick < 95) begin
			c.opcode = OP_STOP;
		end else begin
			c.opcode = OP_UNUSED;
		end
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			c.duration_ms = '0;
		end else if (pick < 75) begin
			c.duration_ms = 16'($urandom_range(1, 12));
		end else if (pick < 90) begin
			c.duration_ms = 16'($urandom);
		end else begin
			c.duration_ms = '1;
		end
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			c.freq_hz = '0;
		end else if (pick < 22) begin
			c.freq_hz = 16'd1;
		end else if (pick < 30) begin
			c.freq_hz = '1;
		end else begin
			c.freq_hz = 16'($urandom);
		end
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			c.beep_count = '0;
		end else if (pick < 75) begin
			c.beep_count = 8'($urandom_range(1, 6));
		end else begin
			c.beep_count = 8'($urandom);
		end
		return c;
	endfunction

	// Offers one command beat at the falling edge and holds it until it is taken.
	// Afterwards the command side may go quiet for a short random burst.
	task automatic send_cmd(input cmd_beat_t beat);
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd       <= beat;
		do @(posedge clk); while (cmd_stall);
		if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			repeat ($urandom_range(1, 9)) begin
				@(negedge clk);
				cmd_valid <= 1'b0;
				cmd       <= random_cmd();
			end
		end
	endtask

	// Stops offering commands and waits until every result has come back, plus
	// a settling wait so the block is surely idle before the next register write.
	task automatic drain();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
	endtask

	// Rewrites every register; only called with the block idle.
	task automatic load_limits(input logic [15:0] min_dur, input logic [15:0] max_dur,
		input logic [15:0] def_freq, input logic [15:0] min_freq,
		input logic [15:0] max_freq, input logic [7:0] max_rep);
		write_reg(REG_MIN_DURATION, min_dur);
		write_reg(REG_MAX_DURATION, max_dur);
		write_reg(REG_DEFAULT_FREQ, def_freq);
		write_reg(REG_MIN_FREQ, min_freq);
		write_reg(REG_MAX_FREQ, max_freq);
		write_reg(REG_MAX_REPEAT, {8'd0, max_rep});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random traffic. A third of the beeps are followed by a train of ticks with
	// random payloads, long enough to walk a sequence through its tone and gap
	// phases and often to its end; the rest is loose commands mixed freely.
	task automatic run_random(input int unsigned items);
		int unsigned sent;
		int unsigned ticks;
		cmd_beat_t   c;
		sent = 0;
		while (sent < items) begin
			c = random_cmd();
			send_cmd(c);
			sent++;
			if (c.opcode == OP_BEEP && $urandom_range(0, 2) == 0) begin
				ticks = $urandom_range(5, 40);
				repeat (ticks) begin
					c = random_cmd();
					c.opcode = OP_TICK;
					send_cmd(c);
				end
				sent += ticks;
			end
		end
	endtask

	initial begin : stimulus
		arst_n       = 1'b0;
		cmd_valid    = 1'b0;
		cmd          = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		hold_req     = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed beats on the reset limits: commands on an idle block, the
		// unused opcode, refused beeps, clamping at both ends, default frequency,
		// a beep replacing a running one and a stop in the middle of a tone.
		send_cmd(pack_cmd(OP_TICK, 16'd0, 16'd0, 8'd0));
		send_cmd(pack_cmd(OP_STOP, 16'hFFFF, 16'hFFFF, 8'hFF));
		send_cmd(pack_cmd(OP_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF));
		send_cmd(pack_cmd(OP_BEEP, 16'd0, 16'd1234, 8'd3));
		send_cmd(pack_cmd(OP_BEEP, 16'hFFFF, 16'hFFFF, 8'hFF));
		send_cmd(pack_cmd(OP_BEEP, 16'd0, 16'd500, 8'd2));
		send_cmd(pack_cmd(OP_UNUSED, 16'd0, 16'd0, 8'd0));
		send_cmd(pack_cmd(OP_TICK, 16'd0, 16'd0, 8'd0));
		send_cmd(pack_cmd(OP_BEEP, 16'd1, 16'd1, 8'd0));
		send_cmd(pack_cmd(OP_BEEP, 16'd7, 16'd0, 8'd1));
		send_cmd(pack_cmd(OP_STOP, 16'd0, 16'd0, 8'd0));
		// Idle again: the frequency of the last sequence must still show.
		send_cmd(pack_cmd(OP_TICK, 16'd0, 16'd0, 8'd0));
		drain();

		// A full three-beep sequence of 2 ms tones and 2 ms gaps, played to its end
		// and then ticked past while idle. The count of 255 clamps to 3.
		load_limits(16'd1, 16'd2, 16'd2000, 16'd100, 16'd10000, 8'd3);
		send_cmd(pack_cmd(OP_BEEP, 16'd2, 16'd440, 8'hFF));
		repeat (13) send_cmd(pack_cmd(OP_TICK, 16'd0, 16'd0, 8'd0));
		drain();

		// Ordinary limits with idling on both sides. In the middle the command
		// side runs flat out while the result side holds off for a long stretch.
		load_limits(16'd1, 16'd8, 16'd1500, 16'd200, 16'd9000, 8'd4);
		tx_gap_pct   = 20;
		rx_stall_pct = 20;
		run_random(150);
		tx_gap_pct = 0;
		hold_req   = 1'b1;
		run_random(100);
		tx_gap_pct = 20;
		run_random(150);
		drain();

		// Inverted limits: below the minimum gives the minimum, else the maximum.
		load_limits(16'd6, 16'd2, 16'd3000, 16'd5000, 16'd300, 8'd255);
		tx_gap_pct   = 0;
		rx_stall_pct = 30;
		run_random(250);
		drain();

		// Widest limits and the largest repeat count.
		load_limits(16'd1, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 8'd255);
		tx_gap_pct   = 30;
		rx_stall_pct = 0;
		run_random(200);
		drain();

		// All limits zero: durations collapse to 1 ms, frequencies to zero and
		// every sequence is a single beep.
		load_limits(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
		tx_gap_pct   = 15;
		rx_stall_pct = 15;
		run_random(200);
		drain();

		// Last stretch at full rate on both sides.
		load_limits(16'd2, 16'd5, 16'd2500, 16'd50, 16'd12000, 8'd6);
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		run_random(300);
		drain();

		if (mismatches == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
